FILE: rtl/ess_pkg.sv
// Shared types for the exchange sort engine: state encoding, cell control and data word.
`default_nettype none

package ess_pkg;

  localparam int DATA_W = 32;

  typedef logic signed [DATA_W-1:0] word_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  // Control broadcast to every cell of the chain
  typedef struct packed {
    logic load;   // advance insertion: compare incoming against held value
    logic shift;  // take the right-hand neighbour's held value
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/ess_cell.sv
// One cell of the insertion chain: holds one value and passes the larger one right.
`default_nettype none

module ess_cell (
  input  wire                clk,
  input  wire                rst,
  input  ess_pkg::cell_ctrl_t ctrl,
  input  wire                in_valid,
  input  ess_pkg::word_t     in_value,
  input  wire                right_valid,
  input  ess_pkg::word_t     right_value,
  output logic               held_valid,
  output ess_pkg::word_t     held_value,
  output logic               pass_valid,
  output ess_pkg::word_t     pass_value
);
  import ess_pkg::*;

  logic in_smaller;

  assign in_smaller = in_value < held_value;

  // Control state: occupancy of the cell and of its pass register
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      pass_valid <= 1'b0;
    end else if (ctrl.shift) begin
      held_valid <= right_valid;
      pass_valid <= 1'b0;
    end else if (ctrl.load) begin
      pass_valid <= in_valid && held_valid;
      if (in_valid) begin
        held_valid <= 1'b1;
      end
    end
  end

  // Payload: keep the smaller value, hand on the larger one; on a shift take the right-hand value
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      held_value <= right_value;
    end else if (ctrl.load && in_valid) begin
      if (!held_valid || in_smaller) begin
        held_value <= in_value;
      end
      pass_value <= (held_valid && in_smaller) ? held_value : in_value;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/exchange_sort_engine.sv
// Top level of the exchange sort engine: cell chain, sequencer and result register.
`default_nettype none

// Sorts a set of signed 32-bit values into ascending order. Items are taken
// one per cycle while busy is low (start high); an item with last set, or the
// item that brings the set to MAX_ELEMENTS, closes the set. The values are
// sorted on the fly by a row of MAX_ELEMENTS cells: each cell keeps the
// smaller of its held value and the value arriving from the left, and hands
// the larger one to its right neighbour through its pass register. Once the
// set is closed busy rises and the chain settles in the drain state, long
// enough for a value to ripple to the far end. The chain then shifts left
// once a cycle, and the results leave one per cycle, smallest first, each
// shown for a single cycle with result_valid high; last_res marks the largest.
// Busy stays high through the drain and emit states; each result is
// registered from the head of the chain as it shifts, so busy falls in the
// very cycle that shows the final result and the next set may start loading
// while it is on the ports. The receiver cannot stall, so it must take every
// result in the cycle it is shown.
module exchange_sort_engine #(
  parameter int MAX_ELEMENTS = 8
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  start,
  output logic                 busy,
  input  ess_pkg::word_t       value,
  input  wire                  last,
  output logic                 result_valid,
  output ess_pkg::word_t       sorted_value,
  output logic                 last_res
);
  import ess_pkg::*;

  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

  state_t            state;
  state_t            state_next;
  cell_ctrl_t        ctrl;
  logic [CNT_W-1:0]  count;    // items held in the current set
  logic [CNT_W-1:0]  timer;    // settle cycles left
  logic              accept;
  logic              set_end;

  logic  cell_valid [MAX_ELEMENTS];
  word_t cell_value [MAX_ELEMENTS];
  logic  pass_valid [MAX_ELEMENTS];
  word_t pass_value [MAX_ELEMENTS];

  assign accept  = start && !busy;
  // Close the set on a marked item or on the item that fills the chain
  assign set_end = last || (count == CNT_W'(MAX_ELEMENTS - 1));

  // Chain of cells: cell 0 holds the smallest value
  for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
    logic  left_valid;
    word_t left_value;
    logic  rgt_valid;
    word_t rgt_value;

    if (i == 0) begin : g_head
      assign left_valid = accept;
      assign left_value = value;
    end else begin : g_body
      assign left_valid = pass_valid[i-1];
      assign left_value = pass_value[i-1];
    end

    if (i == MAX_ELEMENTS - 1) begin : g_tail
      assign rgt_valid = 1'b0;
      assign rgt_value = '0;
    end else begin : g_mid
      assign rgt_valid = cell_valid[i+1];
      assign rgt_value = cell_value[i+1];
    end

    ess_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .in_valid    (left_valid),
      .in_value    (left_value),
      .right_valid (rgt_valid),
      .right_value (rgt_value),
      .held_valid  (cell_valid[i]),
      .held_value  (cell_value[i]),
      .pass_valid  (pass_valid[i]),
      .pass_value  (pass_value[i])
    );
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (accept && set_end) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (timer == '0) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (count == CNT_W'(1)) begin
          state_next = ST_LOAD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    busy       = 1'b1;
    ctrl.load  = 1'b0;
    ctrl.shift = 1'b0;
    case (state)
      ST_LOAD: begin
        busy      = 1'b0;
        ctrl.load = 1'b1;
      end
      ST_DRAIN: begin
        ctrl.load = 1'b1;
      end
      ST_EMIT: begin
        ctrl.shift = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_LOAD;
      count        <= '0;
      timer        <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= (state == ST_EMIT);
      case (state)
        ST_LOAD: begin
          if (accept) begin
            count <= count + CNT_W'(1);
            timer <= CNT_W'(MAX_ELEMENTS - 1);
          end
        end
        ST_DRAIN: begin
          timer <= timer - CNT_W'(1);
        end
        ST_EMIT: begin
          count <= count - CNT_W'(1);
        end
        default: begin
          count <= '0;
        end
      endcase
    end
  end

  // Result register: take the head of the chain while it shifts left
  always_ff @(posedge clk) begin
    if (state == ST_EMIT) begin
      sorted_value <= cell_value[0];
      last_res     <= (count == CNT_W'(1));
    end
  end

`ifndef NO_ASSERTIONS
  // Results are only shown if busy was high at the edge that registered them
  a_result_when_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy))
    else $error("result shown without a preceding busy cycle");

  // An accepted item never coincides with results in the next cycle
  a_no_result_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !result_valid)
    else $error("result emitted right after an accepted item");

  // The final result closes the burst: the engine is free again while it shows
  a_last_ends_burst: assert property (@(posedge clk) disable iff (rst)
    (result_valid && last_res) |-> !busy ##1 !result_valid)
    else $error("results continue after the last one");

  // The head of the chain holds a value in every emit cycle
  a_head_valid: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> cell_valid[0])
    else $error("emitting from an empty chain");
`endif

endmodule

`default_nettype wire
